// ----- hdl/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with an active-low reset that disables checking.
`define ASSERT_CLKD(label, clk_sig, rst_n, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(label, clk_sig, rst_n, cond, msg) \
	`ASSERT_CLKD(label, clk_sig, rst_n, !(cond), msg)

`endif

// ----- hdl/tbsm_pkg.sv -----
package tbsm_pkg;

	// Data path sizes
	localparam int CHUNK_BITS    = 64;
	localparam int COLS_PER_BYTE = 8;
	localparam int IN_TDATA_W    = 3 * CHUNK_BITS;
	localparam int OUT_TDATA_W   = 2 * COLS_PER_BYTE;

	// Limits on the size registers
	localparam int MAX_CHUNKS    = 64;
	localparam int MAX_COL_BYTES = 512;
	localparam int MAX_ROWS      = 65536;

	// Register and counter widths
	localparam int CPD_W       = 7;
	localparam int BGR_W       = 10;
	localparam int ROW_W       = 17;
	localparam int CHUNK_IDX_W = 6;
	localparam int COL_IDX_W   = 3;
	localparam int GRP_IDX_W   = 9;
	localparam int ROW_IDX_W   = 16;
	localparam int PCNT_W      = 7;
	localparam int NET_W       = 8;
	localparam int ACC_W       = 14;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 17;

	// Register indexes on the configuration channel
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHUNKS_PER_DOT = 2'd0,
		CFG_GROUPS_PER_ROW = 2'd1,
		CFG_ROW_TOTAL      = 2'd2
	} cfg_idx_t;

	// Size registers after clamping to their legal range
	typedef struct packed {
		logic [CPD_W-1:0] chunks;
		logic [BGR_W-1:0] groups;
		logic [ROW_W-1:0] rows;
	} tbsm_cfg_t;

	// Number of set bits in one chunk
	function automatic logic [PCNT_W-1:0] popcount64(input logic [CHUNK_BITS-1:0] v);
		logic [PCNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < CHUNK_BITS; i++) begin
			n = n + PCNT_W'(v[i]);
		end
		return n;
	endfunction

endpackage

// ----- hdl/tbsm_cfg_regs.sv -----
module tbsm_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tbsm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tbsm_pkg::CFG_DATA_W-1:0] cfg_data,
	output tbsm_pkg::tbsm_cfg_t             cfg
);
	import tbsm_pkg::*;

	logic [CPD_W-1:0] chunks_q;
	logic [BGR_W-1:0] groups_q;
	logic [ROW_W-1:0] rows_q;
	logic [CPD_W-1:0] chunks_in;
	logic [BGR_W-1:0] groups_in;
	logic [ROW_W-1:0] rows_in;
	logic             wr;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid;

	// Zero reads as one, values past the limit saturate
	always_comb begin
		chunks_in = cfg_data[CPD_W-1:0];
		if (chunks_in == '0) chunks_in = CPD_W'(1);
		else if (chunks_in > CPD_W'(MAX_CHUNKS)) chunks_in = CPD_W'(MAX_CHUNKS);

		groups_in = cfg_data[BGR_W-1:0];
		if (groups_in == '0) groups_in = BGR_W'(1);
		else if (groups_in > BGR_W'(MAX_COL_BYTES)) groups_in = BGR_W'(MAX_COL_BYTES);

		rows_in = cfg_data[ROW_W-1:0];
		if (rows_in == '0) rows_in = ROW_W'(1);
		else if (rows_in > ROW_W'(MAX_ROWS)) rows_in = ROW_W'(MAX_ROWS);
	end

	// Register file; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunks_q <= CPD_W'(1);
			groups_q <= BGR_W'(1);
			rows_q   <= ROW_W'(1);
		end else if (wr) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CHUNKS_PER_DOT: chunks_q <= chunks_in;
				CFG_GROUPS_PER_ROW: groups_q <= groups_in;
				CFG_ROW_TOTAL:      rows_q   <= rows_in;
				default: ;
			endcase
		end
	end

	assign cfg.chunks = chunks_q;
	assign cfg.groups = groups_q;
	assign cfg.rows   = rows_q;

endmodule

// ----- hdl/tbsm_net.sv -----
module tbsm_net (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [tbsm_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	output logic                            net_valid,
	output logic signed [tbsm_pkg::NET_W-1:0] net,
	input  logic                            net_ready
);
	import tbsm_pkg::*;

	logic                  valid_s1;
	logic [CHUNK_BITS-1:0] ap_s1;
	logic [CHUNK_BITS-1:0] am_s1;
	logic [CHUNK_BITS-1:0] b_s1;
	logic                  valid_s2;
	logic signed [NET_W-1:0] net_s2;
	logic [CHUNK_BITS-1:0] pos;
	logic [CHUNK_BITS-1:0] neg;
	logic signed [NET_W-1:0] net_c;
	logic                  adv_s2;

	// Stage 2 moves when empty or when the accumulator takes its beat
	assign adv_s2        = !valid_s2 || net_ready;
	assign s_axis_tready = !valid_s1 || adv_s2;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			ap_s1 <= s_axis_tdata[CHUNK_BITS-1:0];
			am_s1 <= s_axis_tdata[2*CHUNK_BITS-1:CHUNK_BITS];
			b_s1  <= s_axis_tdata[3*CHUNK_BITS-1:2*CHUNK_BITS];
		end
	end

	// Per element sign masks; an element in both planes cancels out
	always_comb begin
		pos   = (ap_s1 | b_s1) & (am_s1 | ~b_s1);
		neg   = (ap_s1 | ~b_s1) & (am_s1 | b_s1);
		net_c = signed'({1'b0, popcount64(pos)}) - signed'({1'b0, popcount64(neg)});
	end

	// Net count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			net_s2 <= net_c;
		end
	end

	assign net_valid = valid_s2;
	assign net       = net_s2;

endmodule

// ----- hdl/tbsm_accum.sv -----
module tbsm_accum (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tbsm_pkg::tbsm_cfg_t               cfg,
	input  logic                              net_valid,
	input  logic signed [tbsm_pkg::NET_W-1:0] net,
	output logic                              net_ready,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [tbsm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	output logic                              m_axis_tlast,
	output logic                              m_axis_tuser
);
	import tbsm_pkg::*;

	logic [CHUNK_IDX_W-1:0]   chunk_idx_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [COL_IDX_W-1:0]     col_q;
	logic [GRP_IDX_W-1:0]     grp_q;
	logic [ROW_IDX_W-1:0]     row_q;
	logic [COLS_PER_BYTE-1:0] plus_q;
	logic [COLS_PER_BYTE-1:0] minus_q;

	logic                     out_valid_q;
	logic [COLS_PER_BYTE-1:0] out_plus_q;
	logic [COLS_PER_BYTE-1:0] out_minus_q;
	logic                     out_row_done_q;
	logic                     out_mat_done_q;

	logic                     dot_end;
	logic                     emit;
	logic                     row_end;
	logic                     mat_end;
	logic                     take;
	logic signed [ACC_W-1:0]  acc_sum;
	logic [COLS_PER_BYTE-1:0] col_bit;
	logic [COLS_PER_BYTE-1:0] plus_next;
	logic [COLS_PER_BYTE-1:0] minus_next;

	// Group boundaries; a counter at or past a lowered limit closes its group
	always_comb begin
		dot_end = ({1'b0, chunk_idx_q} + CPD_W'(1)) >= cfg.chunks;
		emit    = dot_end && (col_q == COL_IDX_W'(COLS_PER_BYTE - 1));
		row_end = ({1'b0, grp_q} + BGR_W'(1)) >= cfg.groups;
		mat_end = row_end && (({1'b0, row_q} + ROW_W'(1)) >= cfg.rows);
	end

	// A beat that closes a byte needs room in the output register
	assign net_ready = !emit || !out_valid_q || m_axis_tready;
	assign take      = net_valid && net_ready;

	// Accumulate and mark the column sign
	always_comb begin
		acc_sum    = acc_q + ACC_W'(net);
		col_bit    = COLS_PER_BYTE'(1) << col_q;
		plus_next  = plus_q;
		minus_next = minus_q;
		if (acc_sum > 0) plus_next = plus_q | col_bit;
		else if (acc_sum < 0) minus_next = minus_q | col_bit;
	end

	// Position counters and partial bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_idx_q <= '0;
			acc_q       <= '0;
			col_q       <= '0;
			grp_q       <= '0;
			row_q       <= '0;
			plus_q      <= '0;
			minus_q     <= '0;
		end else if (take) begin
			if (!dot_end) begin
				chunk_idx_q <= chunk_idx_q + CHUNK_IDX_W'(1);
				acc_q       <= acc_sum;
			end else begin
				chunk_idx_q <= '0;
				acc_q       <= '0;
				if (!emit) begin
					col_q   <= col_q + COL_IDX_W'(1);
					plus_q  <= plus_next;
					minus_q <= minus_next;
				end else begin
					col_q   <= '0;
					plus_q  <= '0;
					minus_q <= '0;
					if (row_end) begin
						grp_q <= '0;
						row_q <= mat_end ? '0 : row_q + ROW_IDX_W'(1);
					end else begin
						grp_q <= grp_q + GRP_IDX_W'(1);
					end
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			out_plus_q     <= plus_next;
			out_minus_q    <= minus_next;
			out_row_done_q <= row_end;
			out_mat_done_q <= mat_end;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_minus_q, out_plus_q};
	assign m_axis_tlast  = out_row_done_q;
	assign m_axis_tuser  = out_mat_done_q;

endmodule

// ----- hdl/ternary_binary_sign_matmul.sv -----
// The beat that closes a byte's eighth column passes the input, net and output registers.
// Throughput: one chunk beat per cycle while m_axis_tready does not stall the output; the
// input register, popcount stage and accumulator stage each advance when the next has room.
// Reset (arst_n low): counters, accumulator and partial bytes clear, all three size
// registers return to one, and no beat is held in the pipeline.
module ternary_binary_sign_matmul (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// a_plus_chunk [63:0], a_minus_chunk [127:64], b_chunk [191:128]
	input  logic [tbsm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// plus_bits [7:0], minus_bits [15:8]
	output logic [tbsm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                             m_axis_tlast,
	// matrix_done [0]
	output logic                             m_axis_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tbsm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tbsm_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import tbsm_pkg::*;

	tbsm_cfg_t         cfg;
	logic              net_valid;
	logic              net_ready;
	logic signed [NET_W-1:0] net;

	tbsm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tbsm_net u_net (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.net_valid     (net_valid),
		.net           (net),
		.net_ready     (net_ready)
	);

	tbsm_accum u_accum (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.net_valid     (net_valid),
		.net           (net),
		.net_ready     (net_ready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// ----- hdl/tbsm_checker.sv -----
`include "assert_macros.svh"

module tbsm_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [tbsm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                             m_axis_tlast,
	input logic                             m_axis_tuser
);
	import tbsm_pkg::*;

	// End of matrix is always also end of row
	`ASSERT_NEVER(a_mat_done_needs_last, clk, arst_n, m_axis_tvalid && m_axis_tuser && !m_axis_tlast, "matrix_done without row_done")

	// A stalled output beat holds
	`ASSERT_CLKD(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "output beat changed while stalled")

	// A fresh output beat must trace back to an accepted input beat
	`ASSERT_CLKD(a_out_latency, clk, arst_n, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 3), "output beat without input beat three cycles before")

endmodule

bind ternary_binary_sign_matmul tbsm_checker u_tbsm_checker (.*);

// ----- tb/sv/ternary_binary_sign_matmul_tb.sv -----
`timescale 1ns / 1ps

module ternary_binary_sign_matmul_tb;
	import tbsm_pkg::*;

	localparam int ITEM_TARGET  = 750;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 12;

	// One output beat: sign bytes plus end flags
	typedef struct packed {
		logic [COLS_PER_BYTE-1:0] plus;
		logic [COLS_PER_BYTE-1:0] minus;
		logic                     row_done;
		logic                     matrix_done;
	} sign_pair_t;

	// Tracks size registers and counters, and holds the byte pairs still owed by the block
	class sign_pair_tracker;
		int unsigned chunks_reg = 1;
		int unsigned groups_reg = 1;
		int unsigned rows_reg   = 1;
		int unsigned chunk_idx  = 0;
		int unsigned col_idx    = 0;
		int unsigned grp_idx    = 0;
		int unsigned row_idx    = 0;
		int          net_sum    = 0;
		logic [COLS_PER_BYTE-1:0] plus_acc  = '0;
		logic [COLS_PER_BYTE-1:0] minus_acc = '0;
		sign_pair_t  pending_pairs[$];
		int          pairs_checked = 0;
		int          fail_count    = 0;

		// Zero reads as one, anything above the limit is capped
		function int unsigned clamp_size(int unsigned v, int unsigned hi);
			if (v == 0)
				return 1;
			if (v > hi)
				return hi;
			return v;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				CFG_CHUNKS_PER_DOT: chunks_reg = 32'(value[CPD_W-1:0]);
				CFG_GROUPS_PER_ROW: groups_reg = 32'(value[BGR_W-1:0]);
				CFG_ROW_TOTAL:      rows_reg   = 32'(value[ROW_W-1:0]);
				default: ;
			endcase
		endfunction

		// Accepted chunk beat: accumulate, close dots and bytes
		function void note_chunk(logic [CHUNK_BITS-1:0] ap, logic [CHUNK_BITS-1:0] am,
				logic [CHUNK_BITS-1:0] b);
			logic [CHUNK_BITS-1:0] pos;
			logic [CHUNK_BITS-1:0] neg;
			int unsigned chunks;
			int unsigned groups;
			int unsigned rows;
			logic        row_end;
			logic        mat_end;
			sign_pair_t  pair;
			pos = (ap | b) & (am | ~b);
			neg = (ap | ~b) & (am | b);
			chunks = clamp_size(chunks_reg, MAX_CHUNKS);
			groups = clamp_size(groups_reg, MAX_COL_BYTES);
			rows = clamp_size(rows_reg, MAX_ROWS);
			net_sum += $countones(pos) - $countones(neg);
			if (chunk_idx + 1 < chunks) begin
				chunk_idx++;
				return;
			end
			chunk_idx = 0;
			if (net_sum > 0)
				plus_acc[col_idx[COL_IDX_W-1:0]] = 1'b1;
			else if (net_sum < 0)
				minus_acc[col_idx[COL_IDX_W-1:0]] = 1'b1;
			net_sum = 0;
			if (col_idx < COLS_PER_BYTE - 1) begin
				col_idx++;
				return;
			end
			col_idx = 0;
			row_end = (grp_idx + 1 >= groups);
			mat_end = row_end && (row_idx + 1 >= rows);
			pair = '{plus_acc, minus_acc, row_end, mat_end};
			pending_pairs.push_back(pair);
			plus_acc = '0;
			minus_acc = '0;
			if (row_end) begin
				grp_idx = 0;
				row_idx = mat_end ? 0 : row_idx + 1;
			end else begin
				grp_idx++;
			end
		endfunction

		// Output beat against the oldest owed pair
		function void check_pair(logic [OUT_TDATA_W-1:0] tdata, logic tlast, logic tuser);
			sign_pair_t got;
			sign_pair_t want;
			got = '{tdata[COLS_PER_BYTE-1:0], tdata[OUT_TDATA_W-1:COLS_PER_BYTE], tlast, tuser};
			if (pending_pairs.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: unexpected beat plus=%02h minus=%02h last=%0b user=%0b",
						$realtime, got.plus, got.minus, got.row_done, got.matrix_done);
				return;
			end
			want = pending_pairs.pop_front();
			pairs_checked++;
			if (got !== want) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: pair %0d exp plus=%02h minus=%02h last=%0b user=%0b, got plus=%02h minus=%02h last=%0b user=%0b",
						$realtime, pairs_checked, want.plus, want.minus, want.row_done,
						want.matrix_done, got.plus, got.minus, got.row_done, got.matrix_done);
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;
	logic                   m_axis_tuser;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	sign_pair_tracker sb;
	bit  in_no_gaps  = 1'b0;
	bit  out_no_gaps = 1'b0;
	int  chunks_sent = 0;
	int  phase_count = 0;
	int  cycle_count = 0;

	ternary_binary_sign_matmul dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pairs still owed", cycle_count,
				sb.pending_pairs.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Output beats
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_pair(m_axis_tdata, m_axis_tlast, m_axis_tuser);
	end

	// Output backpressure: random stall before each beat
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = out_no_gaps ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			@(negedge clk);
		end
	end

	function automatic logic [CHUNK_BITS-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// One chunk beat; starts and ends at a falling edge, leaves tvalid high
	task automatic push_chunk(input logic [CHUNK_BITS-1:0] ap, input logic [CHUNK_BITS-1:0] am,
			input logic [CHUNK_BITS-1:0] b);
		int gap;
		gap = in_no_gaps ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {b, am, ap};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_chunk(ap, am, b);
		chunks_sent++;
		@(negedge clk);
	endtask

	// Register write; leaves cfg_valid high for the caller to drop
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, value);
		@(negedge clk);
	endtask

	// Wait for every owed pair, then let the pipeline empty
	task automatic drain();
		while (sb.pending_pairs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		logic [CHUNK_BITS-1:0] ap;
		logic [CHUNK_BITS-1:0] am;
		logic [CHUNK_BITS-1:0] b;
		logic [CFG_DATA_W-1:0] v_chunks;
		logic [CFG_DATA_W-1:0] v_groups;
		logic [CFG_DATA_W-1:0] v_rows;
		int n_items;
		sb = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_CHUNKS_PER_DOT;
		cfg_data = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: full plus, full minus, both planes, empty A, B flips, cancelling pairs
		push_chunk('1, '0, '0);
		push_chunk('0, '1, '0);
		push_chunk('1, '1, rand64());
		push_chunk('0, '0, rand64());
		push_chunk('1, '0, '1);
		push_chunk('0, '1, '1);
		push_chunk(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, '0);
		push_chunk(64'h8000_0000_0000_0001, '0, 64'h8000_0000_0000_0000);
		repeat (8) begin
			ap = rand64();
			push_chunk(ap, rand64() & ~ap, rand64());
		end
		s_axis_tvalid <= 1'b0;
		drain();

		// Random phases: new sizes each phase, written between input bursts with counters kept
		while (chunks_sent < ITEM_TARGET) begin
			case (phase_count)
				0: begin
					v_chunks = CFG_DATA_W'(MAX_CHUNKS);
					v_groups = CFG_DATA_W'(MAX_COL_BYTES);
					v_rows = CFG_DATA_W'(MAX_ROWS);
				end
				1: begin
					v_chunks = '0;
					v_groups = '0;
					v_rows = '0;
				end
				2: begin
					v_chunks = CFG_DATA_W'({$urandom} | 7'h7F);
					v_groups = CFG_DATA_W'({$urandom} | 10'h3FF);
					v_rows = '1;
				end
				3: begin
					v_chunks = 1;
					v_groups = 2;
					v_rows = 3;
				end
				default: begin
					case ($urandom_range(0, 9))
						0: v_chunks = 0;
						1: v_chunks = CFG_DATA_W'(MAX_CHUNKS);
						2: v_chunks = CFG_DATA_W'($urandom);
						default: v_chunks = CFG_DATA_W'($urandom_range(1, 3));
					endcase
					case ($urandom_range(0, 9))
						0: v_groups = 0;
						1: v_groups = CFG_DATA_W'(MAX_COL_BYTES);
						2: v_groups = CFG_DATA_W'($urandom);
						default: v_groups = CFG_DATA_W'($urandom_range(1, 3));
					endcase
					case ($urandom_range(0, 9))
						0: v_rows = 0;
						1: v_rows = CFG_DATA_W'(MAX_ROWS);
						2: v_rows = CFG_DATA_W'($urandom);
						default: v_rows = CFG_DATA_W'($urandom_range(1, 4));
					endcase
				end
			endcase
			write_reg(CFG_CHUNKS_PER_DOT, v_chunks);
			write_reg(CFG_GROUPS_PER_ROW, v_groups);
			write_reg(CFG_ROW_TOTAL, v_rows);
			cfg_valid <= 1'b0;
			in_no_gaps = ($urandom_range(0, 3) == 0);
			out_no_gaps = ($urandom_range(0, 3) == 0);
			// long dots get a larger beat count
			n_items = (v_chunks[CPD_W-1:0] > 4) ? $urandom_range(16, 150) : $urandom_range(8, 96);
			repeat (n_items) begin
				case ($urandom_range(0, 7))
					0, 1: begin
						ap = rand64();
						am = rand64();
					end
					2, 3: begin
						ap = rand64();
						am = rand64() & ~ap;
					end
					// sparse rows: sums sit near zero
					4: begin
						ap = rand64() & rand64() & rand64();
						am = rand64() & rand64() & rand64() & ~ap;
					end
					5: begin
						ap = '0;
						am = '0;
					end
					// strongly one-sided
					6: begin
						ap = rand64() | rand64();
						am = '0;
					end
					default: begin
						ap = rand64();
						am = ap;
					end
				endcase
				b = ($urandom_range(0, 5) == 0) ? ($urandom_range(0, 1) ? '1 : '0) : rand64();
				push_chunk(ap, am, b);
			end
			s_axis_tvalid <= 1'b0;
			drain();
			phase_count++;
		end

		$display("Sent %0d chunk beats over %0d size settings after the directed start;",
			chunks_sent, phase_count);
		$display("checked %0d sign byte pairs, %0d mismatches.", sb.pairs_checked, sb.fail_count);
		if (sb.fail_count == 0 && sb.pending_pairs.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
